### hw/rtl/ypcp_pkg.sv
// Shared types, constants and the axis mapping function of the YUYV pair converter.
// No dependencies; every other RTL file of the block imports this package.
package ypcp_pkg;

    localparam int CFG_W   = 12;
    localparam int COORD_W = 12;
    localparam int LUMA_W  = 8;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 23;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int REG_W   = 3;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [REG_W-1:0] {
        REG_CAPTURE_WIDTH  = 3'd0,
        REG_CAPTURE_HEIGHT = 3'd1,
        REG_OUTPUT_WIDTH   = 3'd2,
        REG_OUTPUT_HEIGHT  = 3'd3,
        REG_OUTPUT_FORMAT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] dst;
        logic               last;
    } axis_map_t;

    // Payload that travels from the multiply stage to the output register.
    typedef struct packed {
        logic [PROD_W-1:0]  addr_product;
        logic [COORD_W-1:0] dst_x;
        logic [LUMA_W-1:0]  luma_first;
        logic [LUMA_W-1:0]  luma_second;
        logic               last;
    } pair_stage_t;

    // Maps one capture coordinate onto the output axis. The axis is cropped when
    // the output is no larger than the capture, and padded otherwise; the offset
    // is half the difference, rounded down to even on the horizontal axis.
    function automatic axis_map_t map_axis(
        input logic [COORD_W-1:0] pos,
        input logic [1:0]         span,
        input logic [COORD_W-1:0] cap,
        input logic [COORD_W-1:0] out,
        input logic               even
    );
        logic [COORD_W:0] pos_end;
        logic [COORD_W:0] off;
        logic [COORD_W:0] d;
        logic [COORD_W:0] d_end;
        logic             ok;
        axis_map_t        r;
        pos_end = {1'b0, pos} + {{(COORD_W-1){1'b0}}, span};
        if (out <= cap) begin
            off = ({1'b0, cap} - {1'b0, out}) >> 1;
            if (even) begin
                off[0] = 1'b0;
            end
            ok = ({1'b0, pos} >= off);
            d  = {1'b0, pos} - off;
        end
        else begin
            off = ({1'b0, out} - {1'b0, cap}) >> 1;
            if (even) begin
                off[0] = 1'b0;
            end
            ok = 1'b1;
            d  = {1'b0, pos} + off;
        end
        d_end  = d + {{(COORD_W-1){1'b0}}, span};
        r.hit  = ok && (pos_end <= {1'b0, cap}) && (d_end <= {1'b0, out});
        r.dst  = d[COORD_W-1:0];
        r.last = (d_end == {1'b0, out}) || (pos_end == {1'b0, cap});
        return r;
    endfunction

endpackage

### hw/rtl/yuyv_pixel_converter_crop_pad_unit.sv
// YUYV pair converter with center crop or pad: an accepted pair passes through stage 1,
// stage 2 and the output register on its way to out_valid.
// Throughput is one pair per cycle. Input stalls only when the output side holds ready
// low and all three registers in the path are full: stage 1, stage 2 and the output register.
// Reset (rst_n low) clears the position counters and the pipeline valid flags at once and
// loads the register defaults: 640 x 480 capture and output, RGB565 format.
module yuyv_pixel_converter_crop_pad_unit
    import ypcp_pkg::*;
#(
    parameter int MAX_WIDTH  = 3840,
    parameter int MAX_HEIGHT = 2160
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input channel: one YUYV quad per transfer
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [LUMA_W-1:0] luma_first,
    input  logic [LUMA_W-1:0] chroma_u,
    input  logic [LUMA_W-1:0] luma_second,
    input  logic [LUMA_W-1:0] chroma_v,
    input  logic              frame_start,
    // Output channel: one destination pair per transfer
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] pixel_address,
    output logic [PIX_W-1:0]  pixel_first,
    output logic [PIX_W-1:0]  pixel_second,
    output logic              frame_last
);

    // Sizes above the limits are taken as the limits. A limit beyond what the
    // 12-bit registers can hold never bites, so it is capped at the register range.
    localparam int          CFG_MAX      = (1 << CFG_W) - 1;
    localparam logic [11:0] WIDTH_LIMIT  = (MAX_WIDTH > CFG_MAX) ? 12'(CFG_MAX)
                                                                 : 12'(MAX_WIDTH);
    localparam logic [11:0] HEIGHT_LIMIT = (MAX_HEIGHT > CFG_MAX) ? 12'(CFG_MAX)
                                                                  : 12'(MAX_HEIGHT);
    localparam logic [11:0] ROW_MAX      = 12'(CFG_MAX);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cap_width_reg, cap_height_reg;
    logic [CFG_W-1:0] out_width_reg, out_height_reg;
    logic             out_format_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_width_reg  <= 12'd640;
            cap_height_reg <= 12'd480;
            out_width_reg  <= 12'd640;
            out_height_reg <= 12'd480;
            out_format_reg <= 1'b0;
        end
        else if (cfg_write) begin
            unique case (cfg_idx)
                REG_CAPTURE_WIDTH:  cap_width_reg  <= pwdata[CFG_W-1:0];
                REG_CAPTURE_HEIGHT: cap_height_reg <= pwdata[CFG_W-1:0];
                REG_OUTPUT_WIDTH:   out_width_reg  <= pwdata[CFG_W-1:0];
                REG_OUTPUT_HEIGHT:  out_height_reg <= pwdata[CFG_W-1:0];
                REG_OUTPUT_FORMAT:  out_format_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CAPTURE_WIDTH:  prdata = {20'd0, cap_width_reg};
            REG_CAPTURE_HEIGHT: prdata = {20'd0, cap_height_reg};
            REG_OUTPUT_WIDTH:   prdata = {20'd0, out_width_reg};
            REG_OUTPUT_HEIGHT:  prdata = {20'd0, out_height_reg};
            REG_OUTPUT_FORMAT:  prdata = {31'd0, out_format_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Effective sizes. Widths are counted in whole pairs, so bit 0 is dropped.
    logic [COORD_W-1:0] cw, ch, ow, oh;

    always_comb
    begin
        cw    = (cap_width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : cap_width_reg;
        cw[0] = 1'b0;
        ch    = (cap_height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cap_height_reg;
        ow    = (out_width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : out_width_reg;
        ow[0] = 1'b0;
        oh    = (out_height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : out_height_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when its
    // content moves on in the same cycle, so a result waiting in the output
    // register does not stop the stages behind it from filling.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg;
    logic ld2, ld3, accept;

    assign ld3      = v2_reg && (!out_valid || out_ready);
    assign ld2      = v1_reg && (!v2_reg || ld3);
    assign in_ready = !v1_reg || ld2;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Position tracking and mapping, resolved in the cycle of the transfer.
    // A frame_start pair is placed at the frame origin.
    // ------------------------------------------------------------------
    logic [COORD_W-2:0] col_reg, col_next, col_cur;
    logic [COORD_W-1:0] row_reg, row_next, row_cur;
    logic [COORD_W-1:0] col_inc;
    logic               row_wrap;
    axis_map_t          map_x, map_y;
    logic               hit;

    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        map_x    = map_axis({col_cur, 1'b0}, 2'd2, cw, ow, 1'b1);
        map_y    = map_axis(row_cur, 2'd1, ch, oh, 1'b0);
        hit      = map_x.hit && map_y.hit;
        col_inc  = {1'b0, col_cur} + 12'd1;
        // The row ends once the next pair would start at or past the capture width.
        row_wrap = ({col_inc, 1'b0} >= {1'b0, cw});
        col_next = row_wrap ? '0 : col_inc[COORD_W-2:0];
        if (row_wrap && (row_cur != ROW_MAX)) begin
            row_next = row_cur + 12'd1;
        end
        else begin
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            // Pairs that land outside the output frame never occupy a stage.
            if (accept) begin
                v1_reg <= hit;
            end
            else if (ld2) begin
                v1_reg <= 1'b0;
            end
            if (ld2) begin
                v2_reg <= 1'b1;
            end
            else if (ld3) begin
                v2_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload: destination coordinates and the raw samples.
    logic [COORD_W-1:0] s1_dx_reg, s1_dy_reg;
    logic               s1_last_reg;
    logic [LUMA_W-1:0]  s1_y0_reg, s1_y1_reg, s1_u_reg, s1_v_reg;

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_dx_reg   <= map_x.dst;
            s1_dy_reg   <= map_y.dst;
            s1_last_reg <= map_x.last && map_y.last;
            s1_y0_reg   <= luma_first;
            s1_y1_reg   <= luma_second;
            s1_u_reg    <= chroma_u;
            s1_v_reg    <= chroma_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row times output width, alongside the lane multipliers.
    // ------------------------------------------------------------------
    pair_stage_t s2_next, s2_reg;

    always_comb
    begin
        s2_next.addr_product = {{COORD_W{1'b0}}, s1_dy_reg} * {{COORD_W{1'b0}}, ow};
        s2_next.dst_x        = s1_dx_reg;
        s2_next.luma_first   = s1_y0_reg;
        s2_next.luma_second  = s1_y1_reg;
        s2_next.last         = s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld2) begin
            s2_reg <= s2_next;
        end
    end

    logic [PIX_W-1:0] rgb_first, rgb_second;

    ypcp_lane u_lane_first (
        .clk      (clk),
        .load     (ld2),
        .luma     (s1_y0_reg),
        .chroma_u (s1_u_reg),
        .chroma_v (s1_v_reg),
        .rgb      (rgb_first)
    );

    ypcp_lane u_lane_second (
        .clk      (clk),
        .load     (ld2),
        .luma     (s1_y1_reg),
        .chroma_u (s1_u_reg),
        .chroma_v (s1_v_reg),
        .rgb      (rgb_second)
    );

    // ------------------------------------------------------------------
    // Stage 3: format select, address add and the output register.
    // ------------------------------------------------------------------
    ypcp_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (ld3),
        .gray          (out_format_reg),
        .stage         (s2_reg),
        .rgb_first     (rgb_first),
        .rgb_second    (rgb_second),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .pixel_address (pixel_address),
        .pixel_first   (pixel_first),
        .pixel_second  (pixel_second),
        .frame_last    (frame_last)
    );

endmodule

### hw/rtl/ypcp_lane.sv
// One color conversion lane: BT.601 integer YUV to RGB565 with clamping.
// Depends on ypcp_pkg; two copies run side by side, one for each pixel of a pair.
module ypcp_lane
    import ypcp_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [LUMA_W-1:0] luma,
    input  logic [LUMA_W-1:0] chroma_u,
    input  logic [LUMA_W-1:0] chroma_v,
    output logic [PIX_W-1:0]  rgb
);

    logic signed [8:0]  c;
    logic signed [8:0]  d;
    logic signed [8:0]  e;
    logic signed [17:0] yc_next, re_next, gd_next, ge_next, bd_next;
    logic signed [17:0] yc_reg, re_reg, gd_reg, ge_reg, bd_reg;
    logic signed [19:0] r_sum, g_sum, b_sum;
    logic [7:0]         r_ch, g_ch, b_ch;

    // Negative sums clamp to zero; sums at or above 256 * 256 clamp to full scale.
    function automatic logic [7:0] clamp_channel(input logic signed [19:0] t);
        logic [7:0] res;
        if (t[19]) begin
            res = 8'd0;
        end
        else if (|t[18:16]) begin
            res = 8'd255;
        end
        else begin
            res = t[15:8];
        end
        return res;
    endfunction

    always_comb
    begin
        c       = $signed({1'b0, luma}) - 9'sd16;
        d       = $signed({1'b0, chroma_u}) - 9'sd128;
        e       = $signed({1'b0, chroma_v}) - 9'sd128;
        yc_next = 18'sd298 * 18'(c);
        re_next = 18'sd409 * 18'(e);
        gd_next = 18'sd100 * 18'(d);
        ge_next = 18'sd208 * 18'(e);
        bd_next = 18'sd516 * 18'(d);
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            yc_reg <= yc_next;
            re_reg <= re_next;
            gd_reg <= gd_next;
            ge_reg <= ge_next;
            bd_reg <= bd_next;
        end
    end

    always_comb
    begin
        r_sum = 20'(yc_reg) + 20'(re_reg) + 20'sd128;
        g_sum = 20'(yc_reg) - 20'(gd_reg) - 20'(ge_reg) + 20'sd128;
        b_sum = 20'(yc_reg) + 20'(bd_reg) + 20'sd128;
        r_ch  = clamp_channel(r_sum);
        g_ch  = clamp_channel(g_sum);
        b_ch  = clamp_channel(b_sum);
        rgb   = {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
    end

endmodule

### hw/rtl/ypcp_merge.sv
// Output stage: merges the two lane results, the address and the frame flag.
// Depends on ypcp_pkg; holds the output register that faces the downstream side.
module ypcp_merge
    import ypcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              gray,
    input  pair_stage_t       stage,
    input  logic [PIX_W-1:0]  rgb_first,
    input  logic [PIX_W-1:0]  rgb_second,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [ADDR_W-1:0] pixel_address,
    output logic [PIX_W-1:0]  pixel_first,
    output logic [PIX_W-1:0]  pixel_second,
    output logic              frame_last
);

    logic              valid_reg;
    logic [ADDR_W-1:0] addr_next, addr_reg;
    logic [PIX_W-1:0]  first_next, first_reg;
    logic [PIX_W-1:0]  second_next, second_reg;
    logic              last_reg;

    always_comb
    begin
        addr_next = stage.addr_product[ADDR_W-1:0]
                  + {{(ADDR_W-COORD_W){1'b0}}, stage.dst_x};
        if (gray) begin
            first_next  = {{(PIX_W-LUMA_W){1'b0}}, stage.luma_first};
            second_next = {{(PIX_W-LUMA_W){1'b0}}, stage.luma_second};
        end
        else begin
            first_next  = rgb_first;
            second_next = rgb_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (load) begin
            valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            addr_reg   <= addr_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            last_reg   <= stage.last;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_first   = first_reg;
    assign pixel_second  = second_reg;
    assign frame_last    = last_reg;

endmodule

### hw/rtl/ypcp_checker.sv
// Port-level checker for the YUYV pair converter, attached by the bind below.
// Depends on ypcp_pkg for the register indexes and field widths.
module ypcp_checker
    import ypcp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic              pready,
    input logic [4:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] pixel_address,
    input logic [PIX_W-1:0]  pixel_first,
    input logic [PIX_W-1:0]  pixel_second,
    input logic              frame_last
);

    // The output register is cleared by reset, so it is empty in the cycle after reset is sampled low.
    a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_stall_holds_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_address) && $stable(pixel_first)
            && $stable(pixel_second) && $stable(frame_last))
        else $error("result changed while stalled");

    // A capture width write is visible on the next read of that register.
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[4:2] == REG_CAPTURE_WIDTH)
        |=> (paddr[4:2] != REG_CAPTURE_WIDTH) || (prdata[11:0] == $past(pwdata[11:0])))
        else $error("capture width readback mismatch");

endmodule

bind yuyv_pixel_converter_crop_pad_unit ypcp_checker u_ypcp_checker (.*);

### sim/ypcp_pair_checker.sv
// Scoreboard for the YUYV pair converter: follows register writes and input transfers,
// predicts each destination pair and checks the output transfers in arrival order.
// Depends on ypcp_pkg for field widths and register indexes.
module ypcp_pair_checker
    import ypcp_pkg::*;
#(
    parameter int MAX_WIDTH  = 3840,
    parameter int MAX_HEIGHT = 2160
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [LUMA_W-1:0] luma_first,
    input  logic [LUMA_W-1:0] chroma_u,
    input  logic [LUMA_W-1:0] luma_second,
    input  logic [LUMA_W-1:0] chroma_v,
    input  logic              frame_start,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [ADDR_W-1:0] pixel_address,
    input  logic [PIX_W-1:0]  pixel_first,
    input  logic [PIX_W-1:0]  pixel_second,
    input  logic              frame_last,
    output int                mismatches,
    output int                awaiting,
    output int                pairs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_CEILING = 4095;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  first;
        logic [PIX_W-1:0]  second;
        logic              last;
    } dest_pair_t;

    dest_pair_t       expected_pairs[$];

    logic [CFG_W-1:0] capture_w;
    logic [CFG_W-1:0] capture_h;
    logic [CFG_W-1:0] dest_w;
    logic [CFG_W-1:0] dest_h;
    logic             gray_mode;
    int unsigned      pair_col;
    int unsigned      capture_row;

    function automatic int unsigned clip_size(input logic [CFG_W-1:0] v, input int unsigned lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    // Places a span starting at pos onto the destination axis. Crops when the
    // destination is no larger than the source, pads otherwise.
    function automatic bit place_on_axis(
        input  int unsigned pos,
        input  int unsigned span,
        input  int unsigned src_size,
        input  int unsigned dst_size,
        input  bit          even_off,
        output int unsigned dst,
        output bit          at_end
    );
        int unsigned off;
        dst    = 0;
        at_end = 1'b0;
        if (pos + span > src_size) begin
            return 1'b0;
        end
        if (dst_size <= src_size) begin
            off = (src_size - dst_size) / 2;
            if (even_off) begin
                off = off & ~32'd1;
            end
            if (pos < off) begin
                return 1'b0;
            end
            dst = pos - off;
        end
        else begin
            off = (dst_size - src_size) / 2;
            if (even_off) begin
                off = off & ~32'd1;
            end
            dst = pos + off;
        end
        if (dst + span > dst_size) begin
            return 1'b0;
        end
        at_end = (dst + span == dst_size) || (pos + span == src_size);
        return 1'b1;
    endfunction

    function automatic logic [7:0] sat_channel(input int t);
        if (t < 0) begin
            return 8'd0;
        end
        if (t / 256 > 255) begin
            return 8'd255;
        end
        return 8'(t / 256);
    endfunction

    function automatic logic [PIX_W-1:0] rgb565_of(input logic [7:0] y, u, v);
        int         c;
        int         d;
        int         e;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        r = sat_channel(298 * c + 409 * e + 128);
        g = sat_channel(298 * c - 100 * d - 208 * e + 128);
        b = sat_channel(298 * c + 516 * d + 128);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        dest_pair_t  want;
        dest_pair_t  got;
        int unsigned cw;
        int unsigned ch;
        int unsigned ow;
        int unsigned oh;
        int unsigned dx;
        int unsigned dy;
        bit          hit_x;
        bit          hit_y;
        bit          end_x;
        bit          end_y;
        if (!rst_n) begin
            capture_w     = 12'd640;
            capture_h     = 12'd480;
            dest_w        = 12'd640;
            dest_h        = 12'd480;
            gray_mode     = 1'b0;
            pair_col      = 0;
            capture_row   = 0;
            expected_pairs.delete();
            mismatches    = 0;
            awaiting      = 0;
            pairs_checked = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_CAPTURE_WIDTH:  capture_w = pwdata[CFG_W-1:0];
                    REG_CAPTURE_HEIGHT: capture_h = pwdata[CFG_W-1:0];
                    REG_OUTPUT_WIDTH:   dest_w    = pwdata[CFG_W-1:0];
                    REG_OUTPUT_HEIGHT:  dest_h    = pwdata[CFG_W-1:0];
                    REG_OUTPUT_FORMAT:  gray_mode = pwdata[0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready) begin
                got = '{pixel_address, pixel_first, pixel_second, frame_last};
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: unexpected pair addr %0d first %h second %h last %b",
                                 $time, got.address, got.first, got.second, got.last);
                    end
                end
                else begin
                    want = expected_pairs.pop_front();
                    pairs_checked++;
                    if (got.address !== want.address || got.first !== want.first ||
                        got.second !== want.second || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: pair mismatch, expected addr %0d first %h second %h last %b",
                                     $time, want.address, want.first, want.second, want.last);
                            $display("%0t:                  got addr %0d first %h second %h last %b",
                                     $time, got.address, got.first, got.second, got.last);
                        end
                    end
                end
            end

            if (in_valid && in_ready) begin
                if (frame_start) begin
                    pair_col    = 0;
                    capture_row = 0;
                end
                cw    = clip_size(capture_w, MAX_WIDTH) & ~32'd1;
                ch    = clip_size(capture_h, MAX_HEIGHT);
                ow    = clip_size(dest_w, MAX_WIDTH) & ~32'd1;
                oh    = clip_size(dest_h, MAX_HEIGHT);
                hit_x = place_on_axis(pair_col * 2, 2, cw, ow, 1'b1, dx, end_x);
                hit_y = place_on_axis(capture_row, 1, ch, oh, 1'b0, dy, end_y);
                if (hit_x && hit_y) begin
                    want.address = ADDR_W'(dy * ow + dx);
                    if (gray_mode) begin
                        want.first  = {8'h00, luma_first};
                        want.second = {8'h00, luma_second};
                    end
                    else begin
                        want.first  = rgb565_of(luma_first, chroma_u, chroma_v);
                        want.second = rgb565_of(luma_second, chroma_u, chroma_v);
                    end
                    want.last = end_x && end_y;
                    expected_pairs.push_back(want);
                end
                pair_col++;
                if (pair_col * 2 >= cw) begin
                    pair_col = 0;
                    if (capture_row < ROW_CEILING) begin
                        capture_row++;
                    end
                end
            end

            awaiting = expected_pairs.size();
        end
    end

endmodule

### sim/yuyv_pixel_converter_crop_pad_unit_test.sv
// Top of the YUYV pair converter regression: clock, reset, register writes and pair stimulus.
// Depends on ypcp_pkg, yuyv_pixel_converter_crop_pad_unit and ypcp_pair_checker.
module yuyv_pixel_converter_crop_pad_unit_test
    import ypcp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Sizes the block saturates to; these match the default parameters of the block.
    localparam int MAX_W = 3840;
    localparam int MAX_H = 2160;

    // Cycles to wait after the last expected pair before touching the registers.
    // The pipeline is three stages deep; pairs that produce no output are dropped
    // at the input and never occupy a stage.
    localparam int SETTLE = 8;

    // Length of the random part, counted in input transfers including the directed ones.
    localparam int STIMULUS_ITEMS = 480;

    // Watchdog limit on the length of the run.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [LUMA_W-1:0] luma_first = '0;
    logic [LUMA_W-1:0] chroma_u = '0;
    logic [LUMA_W-1:0] luma_second = '0;
    logic [LUMA_W-1:0] chroma_v = '0;
    logic              frame_start = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_first;
    logic [PIX_W-1:0]  pixel_second;
    logic              frame_last;

    int                mismatches;
    int                awaiting;
    int                pairs_checked;

    // When set, the matching side runs without idle cycles for the current setting.
    bit                src_calm = 1'b0;
    bit                sink_calm = 1'b0;
    int                items_sent = 0;
    int                settings_used = 0;
    int unsigned       cycle_count = 0;

    yuyv_pixel_converter_crop_pad_unit dut (.*);

    ypcp_pair_checker pair_checker (.*);

    // 12 ns clock: six high, six low.
    always begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    // Watchdog. A hang anywhere, including a pair that never comes out, ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side. After every output transfer the sink draws a random stall, none
    // when sink_calm is set, and holds ready low for that long before it accepts again.
    // Ready is driven on the falling edge and the transfer is seen on the rising edge.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge clk);
            out_ready <= (hold == 0);
            if (hold > 0) begin
                hold--;
            end
            @(posedge clk);
            if (out_valid && out_ready) begin
                hold = sink_calm ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // Offers one YUYV quad. The sender first idles for a random number of cycles,
    // then raises valid with the payload and holds both until the transfer.
    // When there is no idle, valid simply stays high from the previous transfer.
    task automatic send_pair(input logic [7:0] y0, u, y1, v, input logic fs);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        while (gap > 0) begin
            in_valid <= 1'b0;
            gap--;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        luma_first  <= y0;
        chroma_u    <= u;
        luma_second <= y1;
        chroma_v    <= v;
        frame_start <= fs;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted pair has been checked,
    // then lets the pipeline settle.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaiting != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // One register write: a setup phase, then an access phase that completes at
    // the rising edge where pready is high. The unused upper data bits carry noise,
    // since the block must ignore them.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers are only rewritten once the block is idle. Each new setting also
    // decides whether either side runs without idle cycles for a while.
    task automatic apply_setting(input int cw, ch, ow, oh, input bit gray);
        drain_pipeline();
        write_reg(REG_CAPTURE_WIDTH, 12'(cw));
        write_reg(REG_CAPTURE_HEIGHT, 12'(ch));
        write_reg(REG_OUTPUT_WIDTH, 12'(ow));
        write_reg(REG_OUTPUT_HEIGHT, 12'(oh));
        write_reg(REG_OUTPUT_FORMAT, {11'($urandom()), gray});
        settings_used++;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
    endtask

    // Widths and heights at the edges of the legal range and beyond it, where the
    // block must saturate to its maximum or write nothing at all.
    function automatic int pick_width();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 3;
            4:       return MAX_W;
            5:       return MAX_W + 1;
            default: return 4095;
        endcase
    endfunction

    function automatic int pick_height();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return MAX_H;
            4:       return MAX_H + 1;
            default: return 4095;
        endcase
    endfunction

    // Runs a number of random pairs under one setting. Most of them form whole
    // frames that begin with a start pulse; now and then a start pulse comes early
    // or goes missing, and some frames run on past their last row. With restart
    // clear, only the first pair carries a start pulse and the stream keeps going
    // past the end of the frame.
    task automatic run_setting(input int cw, ch, ow, oh, input bit gray, input int budget,
                               input bit restart);
        int ew;
        int eh;
        int frame_len;
        int pos;
        int k;
        bit fs;
        apply_setting(cw, ch, ow, oh, gray);
        ew        = ((cw > MAX_W) ? MAX_W : cw) & ~1;
        eh        = (ch > MAX_H) ? MAX_H : ch;
        frame_len = ((ew == 0) ? 1 : ew / 2) * ((eh == 0) ? 1 : eh);
        pos       = 0;
        for (k = 0; k < budget; k++) begin
            fs = restart ? (pos == 0) : (k == 0);
            if (restart && $urandom_range(0, 31) == 0) begin
                fs = !fs;
            end
            send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), fs);
            pos = fs ? 1 : pos + 1;
            if (pos >= frame_len && $urandom_range(0, 3) != 0) begin
                pos = 0;
            end
        end
    endtask

    initial begin : stimulus
        int k;

        // Reset is held low from time zero and released on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs under the reset defaults: 640 x 480 in and out, RGB565.
        // Field extremes, clamping of all three channels and a restart mid-row.
        send_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pair(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
        send_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
        send_pair(8'd235, 8'd240, 8'd16, 8'd16, 1'b0);

        // Grayscale: the luma comes through in the low byte and chroma is ignored.
        apply_setting(640, 480, 640, 480, 1'b1);
        send_pair(8'd0, 8'hAA, 8'd255, 8'h55, 1'b1);
        send_pair(8'd255, 8'h55, 8'd0, 8'hAA, 1'b0);

        // Horizontal crop with an odd offset that rounds down to even, together
        // with vertical padding. The whole frame, then two pairs past its end.
        apply_setting(8, 2, 2, 4, 1'b0);
        for (k = 0; k < 10; k++) begin
            send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), k == 0);
        end

        // Horizontal padding with vertical crop, and a restart right after the end of the frame.
        apply_setting(2, 4, 6, 2, 1'b1);
        for (k = 0; k < 6; k++) begin
            send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      k == 0 || k == 4);
        end

        // Fixed settings at the extremes: oversized sizes that saturate, the
        // smallest frame, a tiny frame padded into the largest one, and zero sizes
        // on each axis of either frame.
        run_setting(4095, 4095, 4095, 4095, 1'b0, 40, 1'b1);
        run_setting(2, 1, 2, 1, 1'b1, 10, 1'b1);
        run_setting(2, 1, MAX_W, MAX_H, 1'b0, 6, 1'b1);
        run_setting(0, 4, 8, 4, 1'b0, 8, 1'b1);
        run_setting(8, 0, 8, 4, 1'b1, 8, 1'b1);
        run_setting(8, 4, 0, 4, 1'b0, 8, 1'b1);
        run_setting(8, 4, 8, 0, 1'b1, 8, 1'b1);

        // The random part: mostly small frames so that every row and frame end
        // is reached often, with the odd setting drawn from the extremes.
        while (items_sent < STIMULUS_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                run_setting(pick_width(), pick_height(), pick_width(), pick_height(),
                            1'($urandom_range(0, 1)), $urandom_range(10, 60), 1'b1);
            end
            else begin
                run_setting($urandom_range(0, 24), $urandom_range(0, 6),
                            $urandom_range(0, 24), $urandom_range(0, 6),
                            1'($urandom_range(0, 1)), $urandom_range(10, 60), 1'b1);
            end
        end

        // A narrow frame of 400 rows padded into the largest output: one pair per
        // row, centered low enough that the address reaches its top bit. The stream
        // then runs twenty pairs past the last row, and all of them must be dropped.
        run_setting(2, 400, MAX_W, MAX_H, 1'b0, 420, 1'b0);

        drain_pipeline();
        $display("Sent %0d pair transfers under %0d register settings, crop and pad on both axes.",
                 items_sent, settings_used);
        $display("Compared %0d destination pairs; %0d mismatches.", pairs_checked, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end
        else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ypcp_pkg.sv
hw/rtl/ypcp_lane.sv
hw/rtl/ypcp_merge.sv
hw/rtl/yuyv_pixel_converter_crop_pad_unit.sv
hw/rtl/ypcp_checker.sv
sim/ypcp_pair_checker.sv
sim/yuyv_pixel_converter_crop_pad_unit_test.sv
